// ===== rtl/core/brcr_pkg.sv =====
`default_nettype none

package brcr_pkg;

  // map geometry
  localparam int MAP_BITS   = 1024;
  localparam int SLOT_BITS  = 8;
  localparam int SLOT_SHIFT = 3;
  localparam int MAP_BYTES  = (MAP_BITS + SLOT_BITS - 1) / SLOT_BITS;
  localparam int BYTE_AW    = $clog2(MAP_BYTES);

  // field widths
  localparam int OFF_W = 10;
  localparam int LEN_W = 11;
  localparam int CFG_W = 11;
  localparam int STS_W = 2;

  localparam logic [CFG_W-1:0] BITS_RESET = CFG_W'(1024);

  localparam logic OP_CLAIM = 1'b0;

  typedef enum logic [STS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_COLLISION = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_CHK_RD,
    S_CHK_EV,
    S_WR_RD,
    S_WR_WB,
    S_RESP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    ptr_first;
    logic    ptr_inc;
    logic    mem_rd;
    logic    mem_wr;
    logic    sts_set;
    status_t sts_code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op;
    logic range_bad;
    logic collide;
    logic last_byte;
  } flag_t;

endpackage

`default_nettype wire

// ===== rtl/core/brcr_in_if.sv =====
`default_nettype none

interface brcr_in_if import brcr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [OFF_W-1:0] range_offset;
  logic [LEN_W-1:0] range_length;

  modport source (output valid, op, range_offset, range_length, input ready);
  modport sink   (input valid, op, range_offset, range_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/brcr_out_if.sv =====
`default_nettype none

interface brcr_out_if import brcr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [STS_W-1:0] status;

  modport source (output valid, status, input ready);
  modport sink   (input valid, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/brcr_dp.sv =====
`default_nettype none

module brcr_dp import brcr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             in_op,
  input  wire logic [OFF_W-1:0] in_offset,
  input  wire logic [LEN_W-1:0] in_length,
  input  wire cmd_t             cmd,
  output flag_t                 flags,
  output logic [STS_W-1:0]      status
);

  logic [CFG_W-1:0]     bits_r;
  logic [CFG_W-1:0]     lim;
  logic                 op_r;
  logic [OFF_W-1:0]     off_r;
  logic [LEN_W-1:0]     len_r;
  logic [LEN_W:0]       sum;
  logic [LEN_W:0]       end_full;
  logic [OFF_W-1:0]     end_bit;
  logic [BYTE_AW-1:0]   first_byte;
  logic [BYTE_AW-1:0]   last_byte;
  logic [BYTE_AW-1:0]   ptr_r;
  logic [SLOT_BITS-1:0] mem [MAP_BYTES];
  logic [MAP_BYTES-1:0] vld_r;
  logic [SLOT_BITS-1:0] rd_byte_r;
  logic                 rd_vld_r;
  logic [SLOT_BITS-1:0] cur_byte;
  logic [SLOT_BITS-1:0] mask;
  logic [SLOT_BITS-1:0] new_byte;
  logic [SLOT_SHIFT-1:0] lo_bit;
  logic [SLOT_SHIFT-1:0] hi_bit;
  status_t              status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= BITS_RESET;
    end else if (cfg_we) begin
      bits_r <= cfg_wdata;
    end
  end

  assign lim = (bits_r > CFG_W'(MAP_BITS)) ? CFG_W'(MAP_BITS) : bits_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      off_r <= in_offset;
      len_r <= in_length;
    end
  end

  assign sum        = {2'b00, off_r} + {1'b0, len_r};
  assign end_full   = sum - (LEN_W+1)'(1);
  assign end_bit    = end_full[OFF_W-1:0];
  assign first_byte = BYTE_AW'(off_r >> SLOT_SHIFT);
  assign last_byte  = BYTE_AW'(end_bit >> SLOT_SHIFT);

  always_ff @(posedge clk) begin
    if (cmd.ptr_first) begin
      ptr_r <= first_byte;
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_r + BYTE_AW'(1);
    end
  end

  // byte store, entries read as zero until first written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.mem_wr) begin
      vld_r[ptr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[ptr_r] <= new_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd_byte_r <= mem[ptr_r];
      rd_vld_r  <= vld_r[ptr_r];
    end
  end

  assign cur_byte = rd_vld_r ? rd_byte_r : '0;
  assign lo_bit   = (ptr_r == first_byte) ? off_r[SLOT_SHIFT-1:0] : '0;
  assign hi_bit   = (ptr_r == last_byte) ? end_bit[SLOT_SHIFT-1:0] : '1;

  always_comb begin
    for (int b = 0; b < SLOT_BITS; b++) begin
      mask[b] = (SLOT_SHIFT'(b) >= lo_bit) && (SLOT_SHIFT'(b) <= hi_bit);
    end
  end

  assign new_byte = (op_r == OP_CLAIM) ? (cur_byte | mask) : (cur_byte & ~mask);

  assign flags.op        = op_r;
  assign flags.range_bad = (len_r == '0) || ({1'b0, off_r} >= lim) || (len_r > lim)
                           || (sum > {1'b0, lim});
  assign flags.collide   = |(cur_byte & mask);
  assign flags.last_byte = (ptr_r == last_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= ST_DONE;
    end else if (cmd.sts_set) begin
      status_r <= cmd.sts_code;
    end
  end

  assign status = status_r;

  a_wr_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr |=> vld_r[$past(ptr_r)])
    else $error("written byte not marked valid");

  a_no_step_past_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ptr_inc |-> !flags.last_byte)
    else $error("byte pointer stepped past last byte of run");

  a_collision_on_claim: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sts_set && cmd.sts_code == ST_COLLISION) |-> (op_r == OP_CLAIM))
    else $error("collision reported for a release");

endmodule

`default_nettype wire

// ===== rtl/core/brcr_ctrl.sv =====
`default_nettype none

module brcr_ctrl import brcr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire flag_t flags,
  output cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (flags.range_bad)          state_nxt = S_RESP;
        else if (flags.op == OP_CLAIM) state_nxt = S_CHK_RD;
        else                          state_nxt = S_WR_RD;
      end
      S_CHK_RD: state_nxt = S_CHK_EV;
      S_CHK_EV: begin
        if (flags.collide)        state_nxt = S_RESP;
        else if (flags.last_byte) state_nxt = S_WR_RD;
        else                      state_nxt = S_CHK_RD;
      end
      S_WR_RD: state_nxt = S_WR_WB;
      S_WR_WB: begin
        if (flags.last_byte) state_nxt = S_RESP;
        else                 state_nxt = S_WR_RD;
      end
      S_RESP: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.sts_code = ST_DONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EVAL: begin
        cmd.ptr_first = 1'b1;
        if (flags.range_bad) begin
          cmd.sts_set  = 1'b1;
          cmd.sts_code = ST_RANGE;
        end
      end
      S_CHK_RD: cmd.mem_rd = 1'b1;
      S_CHK_EV: begin
        if (flags.collide) begin
          cmd.sts_set  = 1'b1;
          cmd.sts_code = ST_COLLISION;
        end else if (flags.last_byte) begin
          cmd.ptr_first = 1'b1;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_WR_RD: cmd.mem_rd = 1'b1;
      S_WR_WB: begin
        cmd.mem_wr = 1'b1;
        if (flags.last_byte) begin
          cmd.sts_set  = 1'b1;
          cmd.sts_code = ST_DONE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_RESP: out_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  a_eval_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> $past(in_valid && in_ready))
    else $error("evaluation without an accepted beat");

  a_check_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK_EV) |-> ($past(state_r) == S_CHK_RD))
    else $error("collision check without a preceding read");

  a_wb_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR_WB) |-> ($past(state_r) == S_WR_RD))
    else $error("write-back without a preceding read");

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_range_claim_release_unit.sv =====
// channel  | dir | handshake     | payload
// ---------+-----+---------------+-------------------------------------------
// in_ch    | in  | valid / ready | op, range_offset[9:0], range_length[10:0]
// out_ch   | out | valid / ready | status[1:0]
// cfg      | in  | cfg_we        | cfg_wdata[10:0] (bits_in_use)
//
// one request at a time; a run touches 1..128 map bytes
// a claim checks every byte of the run, then writes each byte; a release only writes;
// out of range goes straight to the result; a claim stops at the first colliding byte
// once the result is taken the unit returns to idle and accepts the next input beat
// the single-port byte store is read then written for each byte
// reset clears the per-byte valid flags at once, so no clearing sweep is needed
// a result held on out_ch blocks the next input beat until it is taken
`default_nettype none

module bitmap_range_claim_release_unit import brcr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  brcr_in_if.sink               in_ch,
  brcr_out_if.source            out_ch
);

  cmd_t  cmd;
  flag_t flags;

  // sequencer: range check, claim check pass, write pass, result
  brcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  // request registers, byte store, masks and held status
  brcr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_op     (in_ch.op),
    .in_offset (in_ch.range_offset),
    .in_length (in_ch.range_length),
    .cmd       (cmd),
    .flags     (flags),
    .status    (out_ch.status)
  );

endmodule

`default_nettype wire
